[design/tpd_pkg.sv]
`timescale 1ns / 1ps
// Package for the touch pressure and pen-detect block: widths, register
// indexes, result kinds and sequencer states. Depends on nothing.
package tpd_pkg;

  localparam int ReadingW = 12;
  localparam int ByteW    = 8;
  localparam int PlateW   = 16;
  localparam int ProdW    = 2 * ReadingW;
  localparam int DivW     = ProdW + PlateW;
  localparam int FracBits = 12;
  localparam int RtW      = DivW - FracBits;
  localparam int CntW     = $clog2(DivW);
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = PlateW;

  localparam logic [ReadingW-1:0] FullScale = '1;

  localparam logic [CfgIdxW-1:0] RegPlate = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLimit = 2'd1;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_TOUCH   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_ERROR   = 2'd3
  } event_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_FIN
  } tpd_state_t;

endpackage

[design/tpd_if.sv]
`timescale 1ns / 1ps
// Valid/ready channels for one converter poll and for one result.
// Depends on nothing.
interface tpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] z1_high;
  logic [7:0] z1_low;
  logic [7:0] z2_high;
  logic [7:0] z2_low;
  logic [7:0] xpos_high;
  logic [7:0] xpos_low;
  logic [7:0] ypos_high;
  logic [7:0] ypos_low;
  modport source (output valid, z1_high, z1_low, z2_high, z2_low,
                  xpos_high, xpos_low, ypos_high, ypos_low, input ready);
  modport sink (input valid, z1_high, z1_low, z2_high, z2_low,
                xpos_high, xpos_low, ypos_high, ypos_low, output ready);
endinterface

interface tpd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic        press_edge;
  logic [11:0] xpos;
  logic [11:0] ypos;
  logic [11:0] pressure;
  modport source (output valid, event_kind, press_edge, xpos, ypos, pressure,
                  input ready);
  modport sink (input valid, event_kind, press_edge, xpos, ypos, pressure,
                output ready);
endinterface

[design/touch_pressure_pen_detect_top.sv]
`timescale 1ns / 1ps
// Touch pressure and pen-detect block: one shared multiplier and a restoring
// divider under a small sequencer. Depends on tpd_pkg and the channels in tpd_if.sv.
//
//  channel   direction  contents
//  in_chan   sink       raw bytes of z1, z2, x and y for one poll
//  out_chan  source     event kind, press edge, x, y and pressure
//  cfg_*     write      plate resistance (index 0), touch limit (index 1)
//
// A result is registered after its request is accepted: the sequencer steps
// through ST_MUL1 and ST_MUL2 on the shared multiplier, ST_DIV for the
// one-bit-per-cycle divider, and the finishing state ST_FIN. The next request
// is taken only once the sequencer is back in idle. Data errors and a z1 of zero
// skip the multiply and divide and go straight from idle to the finishing state.
// Reset clears the pen state and the output valid, returns the sequencer to idle
// and sets the plate and limit registers to their defaults. A new request is taken
// while a result still waits; it finishes only once the output register is free.
module touch_pressure_pen_detect_top (
  input  logic                            clk,
  input  logic                            rst_n,
  tpd_in_if.sink                          in_chan,
  tpd_out_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [tpd_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [tpd_pkg::CfgDataW-1:0]    cfg_wdata
);
  import tpd_pkg::*;

  tpd_state_t             state_r, state_nxt;
  logic [PlateW-1:0]      plate_r;
  logic [ReadingW-1:0]    limit_r;
  logic                   pen_r;

  logic [ReadingW-1:0]    z1_r, z2_r, x_r, y_r;
  logic                   err_r, skip_r;
  logic [ProdW-1:0]       prod1_r;
  logic [DivW-1:0]        quo_r;
  logic [ReadingW-1:0]    rem_r;
  logic [CntW-1:0]        cnt_r;

  logic                   out_valid_r;
  event_kind_t            out_kind_r;
  logic                   out_edge_r;
  logic [ReadingW-1:0]    out_x_r, out_y_r, out_p_r;

  logic                   accept, out_free, div_last, finish;
  logic                   nibble_err, touch;
  logic [ReadingW-1:0]    z1_in, z2_in, x_in, y_in, diff;
  logic [ProdW-1:0]       mul_a;
  logic [PlateW-1:0]      mul_b;
  logic [DivW-1:0]        mul_p;
  logic [ReadingW:0]      rem_sh;
  logic                   div_ge;
  logic [RtW-1:0]         rt;

  assign z1_in = {in_chan.z1_high, in_chan.z1_low[7:4]};
  assign z2_in = {in_chan.z2_high, in_chan.z2_low[7:4]};
  assign x_in  = {in_chan.xpos_high, in_chan.xpos_low[7:4]};
  assign y_in  = {in_chan.ypos_high, in_chan.ypos_low[7:4]};
  assign nibble_err = (in_chan.z1_low[3:0] != 4'd0) || (in_chan.z2_low[3:0] != 4'd0)
                   || (in_chan.xpos_low[3:0] != 4'd0) || (in_chan.ypos_low[3:0] != 4'd0);

  assign accept   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign div_last = (cnt_r == CntW'(DivW - 1));
  assign diff     = (z2_r >= z1_r) ? (z2_r - z1_r) : '0;

  assign mul_a = (state_r == ST_MUL1) ? ProdW'(diff) : prod1_r;
  assign mul_b = (state_r == ST_MUL1) ? PlateW'(x_r) : plate_r;
  assign mul_p = DivW'(mul_a) * DivW'(mul_b);

  assign rem_sh = {rem_r, quo_r[DivW-1]};
  assign div_ge = (rem_sh >= {1'b0, z1_r});
  assign rt     = quo_r[DivW-1:FracBits];
  assign touch  = !skip_r && (rt <= RtW'(limit_r));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = (nibble_err || (z1_in == '0)) ? ST_FIN : ST_MUL1;
        end
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_chan.ready = 1'b0;
    finish        = 1'b0;
    unique case (state_r)
      ST_IDLE: in_chan.ready = 1'b1;
      ST_FIN:  finish = out_free;
      default: begin
        in_chan.ready = 1'b0;
        finish        = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      plate_r     <= '0;
      limit_r     <= FullScale;
      pen_r       <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          RegPlate: plate_r <= cfg_wdata;
          RegLimit: limit_r <= cfg_wdata[ReadingW-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_MUL2) begin
        cnt_r <= '0;
      end else if (state_r == ST_DIV) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
        if (!err_r) begin
          pen_r <= touch;
        end
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      z1_r   <= z1_in;
      z2_r   <= z2_in;
      x_r    <= (x_in == FullScale) ? '0 : x_in;
      y_r    <= y_in;
      err_r  <= nibble_err;
      skip_r <= nibble_err || (z1_in == '0);
    end
    if (state_r == ST_MUL1) begin
      prod1_r <= mul_p[ProdW-1:0];
    end
    if (state_r == ST_MUL2) begin
      quo_r <= mul_p;
      rem_r <= '0;
    end else if (state_r == ST_DIV) begin
      quo_r <= {quo_r[DivW-2:0], div_ge};
      rem_r <= div_ge ? ReadingW'(rem_sh - {1'b0, z1_r}) : rem_sh[ReadingW-1:0];
    end
    if (finish) begin
      if (touch) begin
        out_kind_r <= EV_TOUCH;
        out_edge_r <= !pen_r;
        out_x_r    <= x_r;
        out_y_r    <= y_r;
        out_p_r    <= FullScale - rt[ReadingW-1:0];
      end else begin
        out_edge_r <= 1'b0;
        out_x_r    <= '0;
        out_y_r    <= '0;
        out_p_r    <= '0;
        if (err_r) begin
          out_kind_r <= EV_ERROR;
        end else if (pen_r) begin
          out_kind_r <= EV_RELEASE;
        end else begin
          out_kind_r <= EV_NONE;
        end
      end
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.event_kind = out_kind_r;
  assign out_chan.press_edge = out_edge_r;
  assign out_chan.xpos       = out_x_r;
  assign out_chan.ypos       = out_y_r;
  assign out_chan.pressure   = out_p_r;

  // The pen state reflects the most recent result other than a data error.
  a_touch_pen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == EV_TOUCH)) |-> pen_r)
    else $error("touch result without pen down");

  a_release_pen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == EV_RELEASE)) |-> !pen_r)
    else $error("release result with pen still down");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != ST_IDLE))
    else $error("sequencer stayed idle after a request");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == EV_ERROR)) |->
      (!out_edge_r && (out_x_r == '0) && (out_y_r == '0) && (out_p_r == '0)))
    else $error("data error result carries nonzero fields");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DIV) && div_last) |=> (state_r == ST_FIN))
    else $error("divider did not finish after its last step");

endmodule
